// ===== sv/htf_pkg.sv =====
`default_nettype none

package htf_pkg;

   localparam int MAX_EVENTS  = 3;
   localparam int EV_COUNT_W  = $clog2(MAX_EVENTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CP_W    = 22;
   localparam int VALUE_W = 21;
   localparam int KIND_W  = 4;
   localparam int ERR_W   = 3;
   localparam int STATE_W = 5;
   localparam int START_W = 3;

   // Tokenizer states.
   localparam logic [STATE_W-1:0] ST_DATA        = 5'd0;
   localparam logic [STATE_W-1:0] ST_RCDATA      = 5'd1;
   localparam logic [STATE_W-1:0] ST_RAWTEXT     = 5'd2;
   localparam logic [STATE_W-1:0] ST_SCRIPT      = 5'd3;
   localparam logic [STATE_W-1:0] ST_PLAIN       = 5'd4;
   localparam logic [STATE_W-1:0] ST_TAGOPEN     = 5'd5;
   localparam logic [STATE_W-1:0] ST_ENDTAGOPEN  = 5'd6;
   localparam logic [STATE_W-1:0] ST_TAGNAME     = 5'd7;
   localparam logic [STATE_W-1:0] ST_RCDATA_LT   = 5'd8;
   localparam logic [STATE_W-1:0] ST_RAWTEXT_LT  = 5'd9;
   localparam logic [STATE_W-1:0] ST_SCRIPT_LT   = 5'd10;
   localparam logic [STATE_W-1:0] ST_CHARREF     = 5'd11;
   localparam logic [STATE_W-1:0] ST_MARKUP      = 5'd12;
   localparam logic [STATE_W-1:0] ST_PI_OPEN     = 5'd13;
   localparam logic [STATE_W-1:0] ST_BEFORE_ATTR = 5'd14;
   localparam logic [STATE_W-1:0] ST_SELF_CLOSE  = 5'd15;
   localparam logic [STATE_W-1:0] ST_BOGUS       = 5'd16;

   // Event kinds.
   localparam logic [KIND_W-1:0] EV_CHAR      = 4'd0;
   localparam logic [KIND_W-1:0] EV_START     = 4'd1;
   localparam logic [KIND_W-1:0] EV_END       = 4'd2;
   localparam logic [KIND_W-1:0] EV_NAME      = 4'd3;
   localparam logic [KIND_W-1:0] EV_FINISH    = 4'd4;
   localparam logic [KIND_W-1:0] EV_EOF       = 4'd5;
   localparam logic [KIND_W-1:0] EV_COMMENT   = 4'd6;
   localparam logic [KIND_W-1:0] EV_UNHANDLED = 4'd7;
   localparam logic [KIND_W-1:0] EV_ERROR     = 4'd8;

   // Parse errors.
   localparam logic [ERR_W-1:0] ERR_NONE          = 3'd0;
   localparam logic [ERR_W-1:0] ERR_NULL          = 3'd1;
   localparam logic [ERR_W-1:0] ERR_EOF_BEFORE    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_BAD_FIRST     = 3'd3;
   localparam logic [ERR_W-1:0] ERR_MISSING_NAME  = 3'd4;
   localparam logic [ERR_W-1:0] ERR_EOF_IN_TAG    = 3'd5;

   // Code points.
   localparam logic [VALUE_W-1:0] CP_MAX   = 21'h10FFFF;
   localparam logic [VALUE_W-1:0] CP_REPL  = 21'h00FFFD;
   localparam logic [VALUE_W-1:0] CP_LT    = 21'h00003C;
   localparam logic [VALUE_W-1:0] CP_SLASH = 21'h00002F;
   localparam logic [VALUE_W-1:0] CP_SPACE = 21'h000020;
   localparam logic [VALUE_W-1:0] CP_TAB   = 21'h000009;
   localparam logic [VALUE_W-1:0] CP_LF    = 21'h00000A;
   localparam logic [VALUE_W-1:0] CP_FF    = 21'h00000C;
   localparam logic [VALUE_W-1:0] CP_AMP   = 21'h000026;
   localparam logic [VALUE_W-1:0] CP_GT    = 21'h00003E;
   localparam logic [VALUE_W-1:0] CP_BANG  = 21'h000021;
   localparam logic [VALUE_W-1:0] CP_QUEST = 21'h00003F;
   localparam logic [VALUE_W-1:0] CP_UP_A  = 21'h000041;
   localparam logic [VALUE_W-1:0] CP_UP_Z  = 21'h00005A;
   localparam logic [VALUE_W-1:0] CP_LO_A  = 21'h000061;
   localparam logic [VALUE_W-1:0] CP_LO_Z  = 21'h00007A;
   localparam logic [VALUE_W-1:0] CP_CASE  = 21'h000020;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [ERR_W-1:0]   err;
      logic [STATE_W-1:0] state;
   } event_type;

   // All events caused by one code point, in order.
   typedef struct packed {
      event_type [MAX_EVENTS-1:0] ev;
      logic [EV_COUNT_W-1:0]      count;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== sv/htf_front.sv =====
`default_nettype none

module htf_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [htf_pkg::CP_W-1:0]   req_code_point,
   input  wire logic                              csr_we,
   input  wire logic [htf_pkg::START_W-1:0]       csr_wdata,
   input  wire htf_pkg::queue_status_type         q_status,
   output logic                                   q_push,
   output htf_pkg::entry_type                     q_entry
);

   typedef struct packed {
      logic                        valid;
      htf_pkg::event_type          ev;
      logic [htf_pkg::STATE_W-1:0] next;
   } step_type;

   logic [htf_pkg::STATE_W-1:0] state_ff;
   logic [htf_pkg::STATE_W-1:0] state_in;
   logic                        eof;
   logic [htf_pkg::VALUE_W-1:0] raw_cp;
   logic [htf_pkg::VALUE_W-1:0] cp;
   logic                        accept;
   step_type                    cont_cur;
   step_type                    cont_data;
   step_type                    name_step;
   htf_pkg::entry_type          entry;

   function automatic logic is_alpha(input logic [htf_pkg::VALUE_W-1:0] c);
      return (c >= htf_pkg::CP_UP_A && c <= htf_pkg::CP_UP_Z) ||
             (c >= htf_pkg::CP_LO_A && c <= htf_pkg::CP_LO_Z);
   endfunction

   // One code point in a content state (data through plaintext).
   function automatic step_type content_step(input logic [htf_pkg::STATE_W-1:0] s,
                                             input logic eof_i,
                                             input logic [htf_pkg::VALUE_W-1:0] c);
      step_type r;
      r          = '0;
      r.next     = s;
      r.ev.state = s;
      if (eof_i) begin
         r.valid   = 1'b1;
         r.ev.kind = htf_pkg::EV_EOF;
      end else if (c == htf_pkg::CP_AMP &&
                   (s == htf_pkg::ST_DATA || s == htf_pkg::ST_RCDATA)) begin
         r.next = htf_pkg::ST_CHARREF;
      end else if (c == htf_pkg::CP_LT && s != htf_pkg::ST_PLAIN) begin
         case (s)
            htf_pkg::ST_DATA:    r.next = htf_pkg::ST_TAGOPEN;
            htf_pkg::ST_RCDATA:  r.next = htf_pkg::ST_RCDATA_LT;
            htf_pkg::ST_RAWTEXT: r.next = htf_pkg::ST_RAWTEXT_LT;
            default:             r.next = htf_pkg::ST_SCRIPT_LT;
         endcase
      end else if (c == '0) begin
         r.valid    = 1'b1;
         r.ev.kind  = htf_pkg::EV_CHAR;
         r.ev.value = (s == htf_pkg::ST_DATA) ? '0 : htf_pkg::CP_REPL;
         r.ev.err   = htf_pkg::ERR_NULL;
      end else begin
         r.valid    = 1'b1;
         r.ev.kind  = htf_pkg::EV_CHAR;
         r.ev.value = c;
      end
      return r;
   endfunction

   // One code point in the tag name state.
   function automatic step_type tagname_step(input logic eof_i,
                                             input logic [htf_pkg::VALUE_W-1:0] c);
      step_type r;
      r          = '0;
      r.next     = htf_pkg::ST_TAGNAME;
      r.ev.state = htf_pkg::ST_TAGNAME;
      if (eof_i) begin
         r.valid   = 1'b1;
         r.ev.kind = htf_pkg::EV_EOF;
         r.ev.err  = htf_pkg::ERR_EOF_IN_TAG;
      end else if (c == htf_pkg::CP_TAB || c == htf_pkg::CP_LF ||
                   c == htf_pkg::CP_FF || c == htf_pkg::CP_SPACE) begin
         r.next = htf_pkg::ST_BEFORE_ATTR;
      end else if (c == htf_pkg::CP_SLASH) begin
         r.next = htf_pkg::ST_SELF_CLOSE;
      end else if (c == htf_pkg::CP_GT) begin
         r.valid    = 1'b1;
         r.next     = htf_pkg::ST_DATA;
         r.ev.kind  = htf_pkg::EV_FINISH;
         r.ev.state = htf_pkg::ST_DATA;
      end else if (c == '0) begin
         r.valid    = 1'b1;
         r.ev.kind  = htf_pkg::EV_NAME;
         r.ev.value = htf_pkg::CP_REPL;
         r.ev.err   = htf_pkg::ERR_NULL;
      end else if (c >= htf_pkg::CP_UP_A && c <= htf_pkg::CP_UP_Z) begin
         r.valid    = 1'b1;
         r.ev.kind  = htf_pkg::EV_NAME;
         r.ev.value = c + htf_pkg::CP_CASE;
      end else begin
         r.valid    = 1'b1;
         r.ev.kind  = htf_pkg::EV_NAME;
         r.ev.value = c;
      end
      return r;
   endfunction

   // Any negative input is end of file; values past the Unicode range become U+FFFD.
   assign eof    = req_code_point[htf_pkg::CP_W-1];
   assign raw_cp = req_code_point[htf_pkg::VALUE_W-1:0];
   assign cp     = eof ? '0 : ((raw_cp > htf_pkg::CP_MAX) ? htf_pkg::CP_REPL : raw_cp);

   assign cont_cur  = content_step(state_ff, eof, cp);
   assign cont_data = content_step(htf_pkg::ST_DATA, eof, cp);
   assign name_step = tagname_step(eof, cp);

   always_comb begin
      entry    = '0;
      state_in = state_ff;
      if (state_ff <= htf_pkg::ST_PLAIN) begin
         state_in    = cont_cur.next;
         entry.ev[0] = cont_cur.ev;
         entry.count = {{(htf_pkg::EV_COUNT_W-1){1'b0}}, cont_cur.valid};
      end else begin
         case (state_ff)
            htf_pkg::ST_TAGOPEN: begin
               if (eof) begin
                  state_in          = htf_pkg::ST_DATA;
                  entry.ev[0].kind  = htf_pkg::EV_CHAR;
                  entry.ev[0].value = htf_pkg::CP_LT;
                  entry.ev[0].err   = htf_pkg::ERR_EOF_BEFORE;
                  entry.ev[0].state = htf_pkg::ST_DATA;
                  entry.ev[1]       = cont_data.ev;
                  entry.count       = htf_pkg::EV_COUNT_W'(2);
               end else if (cp == htf_pkg::CP_BANG) begin
                  state_in = htf_pkg::ST_MARKUP;
               end else if (cp == htf_pkg::CP_SLASH) begin
                  state_in = htf_pkg::ST_ENDTAGOPEN;
               end else if (cp == htf_pkg::CP_QUEST) begin
                  state_in = htf_pkg::ST_PI_OPEN;
               end else if (is_alpha(cp)) begin
                  state_in          = htf_pkg::ST_TAGNAME;
                  entry.ev[0].kind  = htf_pkg::EV_START;
                  entry.ev[0].state = htf_pkg::ST_TAGNAME;
                  entry.ev[1]       = name_step.ev;
                  entry.count       = htf_pkg::EV_COUNT_W'(2);
               end else begin
                  // Not a tag: emit the '<' and handle the code point again in data.
                  state_in          = cont_data.next;
                  entry.ev[0].kind  = htf_pkg::EV_CHAR;
                  entry.ev[0].value = htf_pkg::CP_LT;
                  entry.ev[0].err   = htf_pkg::ERR_BAD_FIRST;
                  entry.ev[0].state = htf_pkg::ST_DATA;
                  entry.ev[1]       = cont_data.ev;
                  entry.count       = cont_data.valid ? htf_pkg::EV_COUNT_W'(2)
                                                      : htf_pkg::EV_COUNT_W'(1);
               end
            end
            htf_pkg::ST_ENDTAGOPEN: begin
               if (eof) begin
                  state_in          = htf_pkg::ST_DATA;
                  entry.ev[0].kind  = htf_pkg::EV_CHAR;
                  entry.ev[0].value = htf_pkg::CP_LT;
                  entry.ev[0].err   = htf_pkg::ERR_EOF_BEFORE;
                  entry.ev[0].state = htf_pkg::ST_DATA;
                  entry.ev[1].kind  = htf_pkg::EV_CHAR;
                  entry.ev[1].value = htf_pkg::CP_SLASH;
                  entry.ev[1].state = htf_pkg::ST_DATA;
                  entry.ev[2]       = cont_data.ev;
                  entry.count       = htf_pkg::EV_COUNT_W'(3);
               end else if (cp == htf_pkg::CP_GT) begin
                  state_in          = htf_pkg::ST_DATA;
                  entry.ev[0].kind  = htf_pkg::EV_ERROR;
                  entry.ev[0].err   = htf_pkg::ERR_MISSING_NAME;
                  entry.ev[0].state = htf_pkg::ST_DATA;
                  entry.count       = htf_pkg::EV_COUNT_W'(1);
               end else if (is_alpha(cp)) begin
                  state_in          = htf_pkg::ST_TAGNAME;
                  entry.ev[0].kind  = htf_pkg::EV_END;
                  entry.ev[0].state = htf_pkg::ST_TAGNAME;
                  entry.ev[1]       = name_step.ev;
                  entry.count       = htf_pkg::EV_COUNT_W'(2);
               end else begin
                  // The code point is handed on to the bogus comment state.
                  state_in          = htf_pkg::ST_BOGUS;
                  entry.ev[0].kind  = htf_pkg::EV_COMMENT;
                  entry.ev[0].err   = htf_pkg::ERR_BAD_FIRST;
                  entry.ev[0].state = htf_pkg::ST_BOGUS;
                  entry.ev[1].kind  = htf_pkg::EV_UNHANDLED;
                  entry.ev[1].value = cp;
                  entry.ev[1].state = htf_pkg::ST_BOGUS;
                  entry.count       = htf_pkg::EV_COUNT_W'(2);
               end
            end
            htf_pkg::ST_TAGNAME: begin
               state_in    = name_step.next;
               entry.ev[0] = name_step.ev;
               entry.count = {{(htf_pkg::EV_COUNT_W-1){1'b0}}, name_step.valid};
            end
            default: begin
               entry.ev[0].kind  = htf_pkg::EV_UNHANDLED;
               entry.ev[0].value = eof ? '1 : cp;
               entry.ev[0].state = state_ff;
               entry.count       = htf_pkg::EV_COUNT_W'(1);
            end
         endcase
      end
   end

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && (entry.count != '0);
   assign q_entry   = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htf_pkg::ST_DATA;
      end else if (csr_we) begin
         // Out-of-range start values select the data state.
         state_ff <= (csr_wdata <= htf_pkg::START_W'(htf_pkg::ST_PLAIN))
                     ? htf_pkg::STATE_W'(csr_wdata) : htf_pkg::ST_DATA;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/htf_queue.sv =====
`default_nettype none

module htf_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire htf_pkg::entry_type         push_entry,
   input  wire logic                       pop,
   output htf_pkg::entry_type              head,
   output htf_pkg::queue_status_type       status
);

   htf_pkg::entry_type               slot_ff [htf_pkg::QUEUE_DEPTH];
   logic [htf_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [htf_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [htf_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic                             do_push;
   logic                             do_pop;

   assign status.full  = (count_ff == htf_pkg::QUEUE_CNT_W'(htf_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/htf_back.sv =====
`default_nettype none

module htf_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire htf_pkg::queue_status_type         q_status,
   input  wire htf_pkg::entry_type                q_head,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [htf_pkg::KIND_W-1:0]             rsp_event_kind,
   output logic [htf_pkg::VALUE_W-1:0]            rsp_event_value,
   output logic [htf_pkg::ERR_W-1:0]              rsp_parse_error,
   output logic [htf_pkg::STATE_W-1:0]            rsp_state_after,
   output logic                                   rsp_last_event
);

   htf_pkg::entry_type              work_ff;
   logic                            work_valid_ff;
   logic [htf_pkg::EV_COUNT_W-1:0]  idx_ff;
   logic                            rsp_valid_ff;
   htf_pkg::event_type              rsp_ev_ff;
   logic                            rsp_last_ff;
   logic                            out_free;
   logic                            emit;
   logic                            at_last;
   logic                            work_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = out_free && work_valid_ff;
   assign at_last   = (idx_ff == work_ff.count - 1'b1);
   // The next entry is loaded in the same cycle that the last event of this one leaves.
   assign work_free = !work_valid_ff || (emit && at_last);
   assign q_pop     = work_free && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            work_valid_ff <= 1'b1;
            idx_ff        <= '0;
         end else if (emit && at_last) begin
            work_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff <= q_head;
      end
      if (emit) begin
         rsp_ev_ff   <= work_ff.ev[idx_ff];
         rsp_last_ff <= at_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_ev_ff.kind;
   assign rsp_event_value = rsp_ev_ff.value;
   assign rsp_parse_error = rsp_ev_ff.err;
   assign rsp_state_after = rsp_ev_ff.state;
   assign rsp_last_event  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/html_tokenizer_front_states.sv =====
// HTML tokenizer front end: takes one code point per request (negative means end of
// file) and returns zero to three token events, in order, with the last one flagged.
// The front stage updates the tokenizer state and accepts a request every cycle while
// its four-entry queue has room; the back stage drives one event per cycle from an
// output register while the receiver is ready. The events of a code point leave one
// at a time through the single result port. The first event passes through a queue
// slot, the work register and the output register before it is presented.
// A write to the start state register loads the tokenizer state at once and must only
// happen while the block is idle.
`default_nettype none

module html_tokenizer_front_states (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [htf_pkg::CP_W-1:0]   req_code_point,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [htf_pkg::KIND_W-1:0]             rsp_event_kind,
   output logic [htf_pkg::VALUE_W-1:0]            rsp_event_value,
   output logic [htf_pkg::ERR_W-1:0]              rsp_parse_error,
   output logic [htf_pkg::STATE_W-1:0]            rsp_state_after,
   output logic                                   rsp_last_event,
   input  wire logic                              csr_we,
   input  wire logic [htf_pkg::START_W-1:0]       csr_wdata
);

   htf_pkg::queue_status_type q_status;
   htf_pkg::entry_type        q_entry;
   htf_pkg::entry_type        q_head;
   logic                      q_push;
   logic                      q_pop;

   htf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_point (req_code_point),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   htf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   htf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .rsp_parse_error (rsp_parse_error),
      .rsp_state_after (rsp_state_after),
      .rsp_last_event  (rsp_last_event)
   );

endmodule

`default_nettype wire

// ===== sv/htf_checker.sv =====
`default_nettype none

module htf_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [htf_pkg::KIND_W-1:0]        rsp_event_kind,
   input wire logic [htf_pkg::VALUE_W-1:0]       rsp_event_value,
   input wire logic [htf_pkg::ERR_W-1:0]         rsp_parse_error,
   input wire logic [htf_pkg::STATE_W-1:0]       rsp_state_after,
   input wire logic                              rsp_last_event
);

   // A stalled response holds its kind, value, parse error and last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_event_value) && $stable(rsp_parse_error) &&
      $stable(rsp_last_event))
      else $error("response changed while stalled");

   // Nothing is presented in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A start or end tag event is always followed by its first name character, so it is never flagged as last.
   a_tag_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == htf_pkg::EV_START ||
                    rsp_event_kind == htf_pkg::EV_END) |-> !rsp_last_event)
      else $error("tag start flagged as last event");

   // Name characters are only produced in the tag name state.
   a_name_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == htf_pkg::EV_NAME |->
      rsp_state_after == htf_pkg::ST_TAGNAME)
      else $error("name character outside tag name state");

   // A comment start leads into the bogus comment state with one more event.
   a_comment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == htf_pkg::EV_COMMENT |->
      rsp_state_after == htf_pkg::ST_BOGUS && !rsp_last_event)
      else $error("comment start with wrong state or flag");

endmodule

bind html_tokenizer_front_states htf_checker u_htf_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS  = 245;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 1000;

   typedef struct packed {
      logic [htf_pkg::KIND_W-1:0]  kind;
      logic [htf_pkg::VALUE_W-1:0] value;
      logic [htf_pkg::ERR_W-1:0]   err;
      logic [htf_pkg::STATE_W-1:0] state;
      logic                        last;
   } token_event_type;

   typedef enum {ROW_CODE, ROW_START} row_op_type;

   typedef struct {
      row_op_type               op;
      logic [htf_pkg::CP_W-1:0] cp;
      bit                       typed;
      token_event_type          ev;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [htf_pkg::CP_W-1:0]     req_code_point;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [htf_pkg::KIND_W-1:0]          rsp_event_kind;
   logic [htf_pkg::VALUE_W-1:0]         rsp_event_value;
   logic [htf_pkg::ERR_W-1:0]           rsp_parse_error;
   logic [htf_pkg::STATE_W-1:0]         rsp_state_after;
   logic                                rsp_last_event;
   logic                                csr_we;
   logic [htf_pkg::START_W-1:0]         csr_wdata;

   // Tokenizer state as the block should hold it.
   logic [htf_pkg::STATE_W-1:0] tok_state;
   logic [htf_pkg::STATE_W-1:0] tok_return_state;
   logic [htf_pkg::START_W-1:0] start_sel;

   token_event_type step_events[$];
   token_event_type awaited_events[$];

   bit no_stall = 1'b0;
   int error_count = 0;
   int requests_sent = 0;
   int events_checked = 0;
   int triple_steps = 0;
   int phases_run = 0;
   int idle_cycles = 0;

   html_tokenizer_front_states u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_point  (req_code_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_value (rsp_event_value),
      .rsp_parse_error (rsp_parse_error),
      .rsp_state_after (rsp_state_after),
      .rsp_last_event  (rsp_last_event),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void load_start_state(input logic [htf_pkg::START_W-1:0] v);
      start_sel = v;
      tok_state = (v <= htf_pkg::ST_PLAIN) ? {2'b00, v} : htf_pkg::ST_DATA;
      tok_return_state = htf_pkg::ST_DATA;
   endfunction

   function automatic void note_event(input logic [htf_pkg::KIND_W-1:0] kind,
                                      input logic [htf_pkg::VALUE_W-1:0] value,
                                      input logic [htf_pkg::ERR_W-1:0] err);
      if (step_events.size() < htf_pkg::MAX_EVENTS)
         step_events.push_back('{kind, value, err, tok_state, 1'b0});
   endfunction

   function automatic bit is_letter(input logic [htf_pkg::VALUE_W-1:0] ch);
      return (ch >= htf_pkg::CP_UP_A && ch <= htf_pkg::CP_UP_Z) ||
             (ch >= htf_pkg::CP_LO_A && ch <= htf_pkg::CP_LO_Z);
   endfunction

   function automatic logic [htf_pkg::CP_W-1:0] cp_of(input logic [31:0] v);
      return v[htf_pkg::CP_W-1:0];
   endfunction

   // Runs one code point through the tokenizer states; a state that hands the
   // code point on sets again, and the new state sees it in the next pass.
   function automatic void tokenize_code_point(input logic [htf_pkg::CP_W-1:0] cp);
      logic                        eof;
      logic [htf_pkg::VALUE_W-1:0] ch;
      bit                          again;
      int                          pass;
      step_events.delete();
      eof = cp[htf_pkg::CP_W-1];
      ch = eof ? '0 : cp[htf_pkg::VALUE_W-1:0];
      if (!eof && ch > htf_pkg::CP_MAX)
         ch = htf_pkg::CP_REPL;
      again = 1'b1;
      for (pass = 0; pass < 4 && again; pass++) begin
         again = 1'b0;
         if (tok_state <= htf_pkg::ST_PLAIN) begin
            if (eof) begin
               note_event(htf_pkg::EV_EOF, '0, htf_pkg::ERR_NONE);
            end else if (ch == htf_pkg::CP_AMP &&
                         (tok_state == htf_pkg::ST_DATA ||
                          tok_state == htf_pkg::ST_RCDATA)) begin
               tok_return_state = tok_state;
               tok_state = htf_pkg::ST_CHARREF;
            end else if (ch == htf_pkg::CP_LT && tok_state != htf_pkg::ST_PLAIN) begin
               case (tok_state)
                  htf_pkg::ST_DATA:    tok_state = htf_pkg::ST_TAGOPEN;
                  htf_pkg::ST_RCDATA:  tok_state = htf_pkg::ST_RCDATA_LT;
                  htf_pkg::ST_RAWTEXT: tok_state = htf_pkg::ST_RAWTEXT_LT;
                  default:             tok_state = htf_pkg::ST_SCRIPT_LT;
               endcase
            end else if (ch == '0) begin
               note_event(htf_pkg::EV_CHAR,
                          (tok_state == htf_pkg::ST_DATA) ? '0 : htf_pkg::CP_REPL,
                          htf_pkg::ERR_NULL);
            end else begin
               note_event(htf_pkg::EV_CHAR, ch, htf_pkg::ERR_NONE);
            end
         end else if (tok_state == htf_pkg::ST_TAGOPEN) begin
            again = 1'b1;
            if (eof) begin
               tok_state = htf_pkg::ST_DATA;
               note_event(htf_pkg::EV_CHAR, htf_pkg::CP_LT, htf_pkg::ERR_EOF_BEFORE);
            end else if (ch == htf_pkg::CP_BANG) begin
               tok_state = htf_pkg::ST_MARKUP;
               again = 1'b0;
            end else if (ch == htf_pkg::CP_SLASH) begin
               tok_state = htf_pkg::ST_ENDTAGOPEN;
               again = 1'b0;
            end else if (ch == htf_pkg::CP_QUEST) begin
               tok_state = htf_pkg::ST_PI_OPEN;
               again = 1'b0;
            end else if (is_letter(ch)) begin
               tok_state = htf_pkg::ST_TAGNAME;
               note_event(htf_pkg::EV_START, '0, htf_pkg::ERR_NONE);
            end else begin
               tok_state = htf_pkg::ST_DATA;
               note_event(htf_pkg::EV_CHAR, htf_pkg::CP_LT, htf_pkg::ERR_BAD_FIRST);
            end
         end else if (tok_state == htf_pkg::ST_ENDTAGOPEN) begin
            again = 1'b1;
            if (eof) begin
               tok_state = htf_pkg::ST_DATA;
               note_event(htf_pkg::EV_CHAR, htf_pkg::CP_LT, htf_pkg::ERR_EOF_BEFORE);
               note_event(htf_pkg::EV_CHAR, htf_pkg::CP_SLASH, htf_pkg::ERR_NONE);
            end else if (ch == htf_pkg::CP_GT) begin
               tok_state = htf_pkg::ST_DATA;
               note_event(htf_pkg::EV_ERROR, '0, htf_pkg::ERR_MISSING_NAME);
               again = 1'b0;
            end else if (is_letter(ch)) begin
               tok_state = htf_pkg::ST_TAGNAME;
               note_event(htf_pkg::EV_END, '0, htf_pkg::ERR_NONE);
            end else begin
               tok_state = htf_pkg::ST_BOGUS;
               note_event(htf_pkg::EV_COMMENT, '0, htf_pkg::ERR_BAD_FIRST);
            end
         end else if (tok_state == htf_pkg::ST_TAGNAME) begin
            if (eof) begin
               note_event(htf_pkg::EV_EOF, '0, htf_pkg::ERR_EOF_IN_TAG);
            end else if (ch == htf_pkg::CP_TAB || ch == htf_pkg::CP_LF ||
                         ch == htf_pkg::CP_FF || ch == htf_pkg::CP_SPACE) begin
               tok_state = htf_pkg::ST_BEFORE_ATTR;
            end else if (ch == htf_pkg::CP_SLASH) begin
               tok_state = htf_pkg::ST_SELF_CLOSE;
            end else if (ch == htf_pkg::CP_GT) begin
               tok_state = htf_pkg::ST_DATA;
               note_event(htf_pkg::EV_FINISH, '0, htf_pkg::ERR_NONE);
            end else if (ch == '0) begin
               note_event(htf_pkg::EV_NAME, htf_pkg::CP_REPL, htf_pkg::ERR_NULL);
            end else if (ch >= htf_pkg::CP_UP_A && ch <= htf_pkg::CP_UP_Z) begin
               note_event(htf_pkg::EV_NAME, ch + htf_pkg::CP_CASE, htf_pkg::ERR_NONE);
            end else begin
               note_event(htf_pkg::EV_NAME, ch, htf_pkg::ERR_NONE);
            end
         end else begin
            note_event(htf_pkg::EV_UNHANDLED, eof ? '1 : ch, htf_pkg::ERR_NONE);
         end
      end
      if (step_events.size() > 0)
         step_events[step_events.size() - 1].last = 1'b1;
   endfunction

   // Mostly well-formed markup for the state the tokenizer is in, with noise mixed in.
   function automatic logic [htf_pkg::CP_W-1:0] next_code_point();
      int                          roll;
      logic [31:0]                 pick;
      logic [htf_pkg::VALUE_W-1:0] letter;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 25);
      letter = ($urandom_range(0, 1) ? htf_pkg::CP_UP_A : htf_pkg::CP_LO_A) +
               pick[htf_pkg::VALUE_W-1:0];
      case (tok_state)
         htf_pkg::ST_TAGOPEN: begin
            if (roll < 70) return {1'b0, letter};
            if (roll < 82) return {1'b0, htf_pkg::CP_SLASH};
         end
         htf_pkg::ST_ENDTAGOPEN: begin
            if (roll < 75) return {1'b0, letter};
            if (roll < 85) return {1'b0, htf_pkg::CP_GT};
         end
         htf_pkg::ST_TAGNAME: begin
            if (roll < 60) return {1'b0, letter};
            if (roll < 82) return {1'b0, htf_pkg::CP_GT};
            if (roll < 85) return '0;
         end
         htf_pkg::ST_DATA, htf_pkg::ST_RCDATA, htf_pkg::ST_RAWTEXT, htf_pkg::ST_SCRIPT,
         htf_pkg::ST_PLAIN: begin
            if (roll < 62) return cp_of($urandom_range(32, 126));
            if (roll < ((tok_state == htf_pkg::ST_DATA) ? 78 : 65))
               return {1'b0, htf_pkg::CP_LT};
         end
         default: ;
      endcase
      case ($urandom_range(0, 8))
         0: return '0;
         1: return cp_of($urandom_range(22'h200000, 22'h3FFFFF));
         2: return cp_of($urandom_range(0, 22'h10FFFF));
         3: return cp_of($urandom_range(22'h110000, 22'h1FFFFF));
         4: return {1'b0, htf_pkg::CP_AMP};
         5: return {1'b0, $urandom_range(0, 1) ? htf_pkg::CP_QUEST : htf_pkg::CP_BANG};
         6: begin
            case ($urandom_range(0, 3))
               0: return {1'b0, htf_pkg::CP_TAB};
               1: return {1'b0, htf_pkg::CP_LF};
               2: return {1'b0, htf_pkg::CP_FF};
               default: return {1'b0, htf_pkg::CP_SPACE};
            endcase
         end
         7: return {1'b0, htf_pkg::CP_SLASH};
         default: return cp_of($urandom_range(128, 16'hFFFF));
      endcase
   endfunction

   function automatic stim_row_type code_row(input logic [htf_pkg::CP_W-1:0] cp);
      stim_row_type row;
      row.op = ROW_CODE;
      row.cp = cp;
      row.typed = 1'b0;
      row.ev = '0;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [htf_pkg::CP_W-1:0] cp,
                                                input logic [htf_pkg::KIND_W-1:0] kind,
                                                input logic [htf_pkg::VALUE_W-1:0] value,
                                                input logic [htf_pkg::ERR_W-1:0] err,
                                                input logic [htf_pkg::STATE_W-1:0] state);
      stim_row_type row;
      row = code_row(cp);
      row.typed = 1'b1;
      row.ev = '{kind, value, err, state, 1'b1};
      return row;
   endfunction

   function automatic stim_row_type start_row(input logic [htf_pkg::START_W-1:0] v);
      stim_row_type row;
      row = code_row({{(htf_pkg::CP_W - htf_pkg::START_W){1'b0}}, v});
      row.op = ROW_START;
      return row;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Holds the request until accepted, then queues the events it should cause.
   task automatic send_code_point(input logic [htf_pkg::CP_W-1:0] cp, input bit typed,
                                  input token_event_type typed_ev);
      @(negedge clock);
      while (!no_stall && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_point <= cp;
      do @(posedge clock); while (!req_ready);
      tokenize_code_point(cp);
      if (typed) begin
         step_events.delete();
         step_events.push_back(typed_ev);
      end
      if (step_events.size() == htf_pkg::MAX_EVENTS)
         triple_steps++;
      foreach (step_events[i])
         awaited_events.push_back(step_events[i]);
      requests_sent++;
   endtask

   task automatic drain_events();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_events.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_start_state(input logic [htf_pkg::START_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      load_start_state(v);
      phases_run++;
   endtask

   always @(negedge clock)
      rsp_ready <= no_stall || ($urandom_range(0, 99) >= 22);

   always @(posedge clock) begin : event_monitor
      token_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         events_checked++;
         if (awaited_events.size() == 0) begin
            flag_error($sformatf("unexpected event kind %0d value %0h",
                                 rsp_event_kind, rsp_event_value));
         end else begin
            want = awaited_events.pop_front();
            check_field("event_kind", 32'(rsp_event_kind), 32'(want.kind));
            check_field("event_value", 32'(rsp_event_value), 32'(want.value));
            check_field("parse_error", 32'(rsp_parse_error), 32'(want.err));
            check_field("state_after", 32'(rsp_state_after), 32'(want.state));
            check_field("last_event", 32'(rsp_last_event), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timed out with %0d events still awaited", awaited_events.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type                rows[$];
      token_event_type             blank;
      logic [htf_pkg::START_W-1:0] start_order[8];
      int                          random_items;
      int                          phase;
      int                          len;
      int                          stuck_left;
      int                          k;

      reset = 1'b1;
      req_valid = 1'b0;
      req_code_point = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      blank = '0;
      random_items = 0;
      phase = 0;
      start_order = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6};
      load_start_state('0);

      // Data state after reset: plain characters, null, range edges, end of file.
      rows.push_back(checked_row(22'h61, htf_pkg::EV_CHAR, 21'h61, htf_pkg::ERR_NONE,
                                 htf_pkg::ST_DATA));
      rows.push_back(checked_row('0, htf_pkg::EV_CHAR, '0, htf_pkg::ERR_NULL,
                                 htf_pkg::ST_DATA));
      rows.push_back(checked_row({1'b0, htf_pkg::CP_MAX}, htf_pkg::EV_CHAR,
                                 htf_pkg::CP_MAX, htf_pkg::ERR_NONE, htf_pkg::ST_DATA));
      rows.push_back(checked_row(22'h1FFFFF, htf_pkg::EV_CHAR, htf_pkg::CP_REPL,
                                 htf_pkg::ERR_NONE, htf_pkg::ST_DATA));
      rows.push_back(checked_row('1, htf_pkg::EV_EOF, '0, htf_pkg::ERR_NONE,
                                 htf_pkg::ST_DATA));
      // Start tag with an upper-case letter and a null in its name.
      rows.push_back(code_row({1'b0, htf_pkg::CP_LT}));
      rows.push_back(code_row(22'h51));
      rows.push_back(checked_row('0, htf_pkg::EV_NAME, htf_pkg::CP_REPL,
                                 htf_pkg::ERR_NULL, htf_pkg::ST_TAGNAME));
      rows.push_back(checked_row({1'b0, htf_pkg::CP_GT}, htf_pkg::EV_FINISH, '0,
                                 htf_pkg::ERR_NONE, htf_pkg::ST_DATA));
      // Empty end tag, then end of file right after the slash.
      rows.push_back(code_row({1'b0, htf_pkg::CP_LT}));
      rows.push_back(code_row({1'b0, htf_pkg::CP_SLASH}));
      rows.push_back(checked_row({1'b0, htf_pkg::CP_GT}, htf_pkg::EV_ERROR, '0,
                                 htf_pkg::ERR_MISSING_NAME, htf_pkg::ST_DATA));
      rows.push_back(code_row({1'b0, htf_pkg::CP_LT}));
      rows.push_back(code_row({1'b0, htf_pkg::CP_SLASH}));
      rows.push_back(code_row('1));
      rows.push_back(code_row({1'b0, htf_pkg::CP_LT}));
      rows.push_back(code_row(22'h61));
      rows.push_back(checked_row('1, htf_pkg::EV_EOF, '0, htf_pkg::ERR_EOF_IN_TAG,
                                 htf_pkg::ST_TAGNAME));
      rows.push_back(start_row(3'd3));
      rows.push_back(checked_row('0, htf_pkg::EV_CHAR, htf_pkg::CP_REPL,
                                 htf_pkg::ERR_NULL, htf_pkg::ST_SCRIPT));
      rows.push_back(code_row({1'b0, htf_pkg::CP_LT}));
      rows.push_back(checked_row(22'h78, htf_pkg::EV_UNHANDLED, 21'h78,
                                 htf_pkg::ERR_NONE, htf_pkg::ST_SCRIPT_LT));
      // An out-of-range start value falls back to data.
      rows.push_back(start_row(3'd7));
      rows.push_back(code_row({1'b0, htf_pkg::CP_LT}));
      rows.push_back(code_row({1'b0, htf_pkg::CP_QUEST}));
      rows.push_back(checked_row(22'h200000, htf_pkg::EV_UNHANDLED, '1,
                                 htf_pkg::ERR_NONE, htf_pkg::ST_PI_OPEN));
      rows.push_back(start_row(3'd4));
      rows.push_back(checked_row({1'b0, htf_pkg::CP_LT}, htf_pkg::EV_CHAR,
                                 htf_pkg::CP_LT, htf_pkg::ERR_NONE, htf_pkg::ST_PLAIN));
      rows.push_back(start_row(3'd1));
      rows.push_back(code_row({1'b0, htf_pkg::CP_AMP}));
      rows.push_back(checked_row({1'b0, htf_pkg::CP_LT}, htf_pkg::EV_UNHANDLED,
                                 htf_pkg::CP_LT, htf_pkg::ERR_NONE, htf_pkg::ST_CHARREF));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].op == ROW_START) begin
            drain_events();
            write_start_state(rows[i].cp[htf_pkg::START_W-1:0]);
         end else begin
            send_code_point(rows[i].cp, rows[i].typed, rows[i].ev);
         end
      end

      // Random phases, each from a fresh start state; a phase ends when its length runs out,
      // or soon after the tokenizer enters a state it only echoes from.
      while (random_items < RANDOM_ITEMS) begin
         drain_events();
         write_start_state(phase < 8 ? start_order[phase] : 3'($urandom_range(0, 7)));
         no_stall = (phase == 3);
         len = $urandom_range(15, 45);
         stuck_left = $urandom_range(1, 3);
         for (k = 0; k < len && random_items < RANDOM_ITEMS; k++) begin
            send_code_point(next_code_point(), 1'b0, blank);
            random_items++;
            if (tok_state > htf_pkg::ST_TAGNAME) begin
               if (stuck_left == 0)
                  break;
               stuck_left--;
            end
         end
         phase++;
      end
      no_stall = 1'b0;
      drain_events();

      $display("Sent %0d requests over %0d start-state phases; checked %0d token events.",
               requests_sent, phases_run, events_checked);
      $display("%0d requests produced three events each; %0d mismatches found.",
               triple_steps, error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
